[rtl/assert_macros.svh]
// assertion macros shared by the sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/rss_pkg.sv]
// shared types and constants of the record sorter
package rss_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_W       = 16;
  localparam int NODE_W      = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // one stored record as seen by the neighbor cells
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
  } entry_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              ins;
    logic              shift;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

[rtl/record_sort_by_score_top.sv]
// record sorter top level: load sequencer, cell chain and output register
// after the last item's beat the sequencer enters drain; each drain step loads the head record into the output register
// throughput: one beat per cycle while loading, one result per cycle while draining
//   and the output is not stalled; input stalls for the whole drain of a batch
// a load insert costs one compare per cell plus a shift of larger records one cell to the right
// reset: synchronous; clears cell valid flags, fill count, state and output valid
`include "assert_macros.svh"

module record_sort_by_score_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rss_pkg::NODE_W-1:0]  node_id,
  input  logic [rss_pkg::KEY_W-1:0]   score,
  input  logic                        last_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rss_pkg::NODE_W-1:0]  sorted_node,
  output logic [rss_pkg::KEY_W-1:0]   sorted_score,
  output logic                        run_end
);

  rss_pkg::state_t            state;
  logic [rss_pkg::CNT_W-1:0]  fill_count;
  rss_pkg::cell_ctrl_t        ctrl;
  rss_pkg::entry_t            ents  [rss_pkg::MAX_ENTRIES];
  logic                       takes [rss_pkg::MAX_ENTRIES];
  logic [rss_pkg::MAX_ENTRIES-1:0] valid_vec;
  rss_pkg::entry_t            head_ent;
  rss_pkg::entry_t            tail_ent;
  logic                       in_beat;
  logic                       room;
  logic                       drain_step;

  // handshake
  assign in_stall   = (state != rss_pkg::ST_LOAD);
  assign in_beat    = in_valid && !in_stall;
  assign room       = (fill_count < rss_pkg::CNT_W'(rss_pkg::MAX_ENTRIES));
  assign drain_step = (state == rss_pkg::ST_DRAIN) && (!out_valid || !out_stall);

  // broadcast to the chain
  assign ctrl.ins   = in_beat && room;
  assign ctrl.shift = drain_step;
  assign ctrl.key   = score;
  assign ctrl.node  = node_id;

  // sentinels at both ends of the chain
  assign head_ent.valid = 1'b1;
  assign head_ent.key   = '0;
  assign head_ent.node  = '0;
  assign tail_ent.valid = 1'b0;
  assign tail_ent.key   = '0;
  assign tail_ent.node  = '0;

  // cell chain, head holds the smallest key
  for (genvar i = 0; i < rss_pkg::MAX_ENTRIES; i++) begin : g_cell
    rss_pkg::entry_t left_ent;
    rss_pkg::entry_t right_ent;
    logic            left_take;

    if (i == 0) begin : g_head
      assign left_ent  = head_ent;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_ent  = ents[i-1];
      assign left_take = takes[i-1];
    end

    if (i == rss_pkg::MAX_ENTRIES - 1) begin : g_tail
      assign right_ent = tail_ent;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    rss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left_ent  (left_ent),
      .left_take (left_take),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .take      (takes[i])
    );

    assign valid_vec[i] = ents[i].valid;
  end

  // sequencer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rss_pkg::ST_LOAD;
      fill_count <= '0;
    end else begin
      case (state)
        rss_pkg::ST_LOAD: begin
          if (in_beat) begin
            if (last_item) begin
              state      <= rss_pkg::ST_DRAIN;
              fill_count <= '0;
            end else if (room) begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        rss_pkg::ST_DRAIN: begin
          if (drain_step && !ents[1].valid) begin
            state <= rss_pkg::ST_LOAD;
          end
        end
        default: begin
          state <= rss_pkg::ST_LOAD;
        end
      endcase
    end
  end

  // output register fed from the head cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      sorted_node  <= ents[0].node;
      sorted_score <= ents[0].key;
      run_end      <= !ents[1].valid;
    end
  end

  // while loading, the count matches the occupied cells
  `ASSERT_IMPLY(a_count, state == rss_pkg::ST_LOAD,
                $countones(valid_vec) == 32'(fill_count), "fill count mismatch")
  // a drain step always finds a record at the head
  `ASSERT_IMPLY(a_head, drain_step, ents[0].valid, "drain from empty chain")

endmodule

[rtl/rss_cell.sv]
// one cell of the insertion sort chain
`include "assert_macros.svh"

module rss_cell (
  input  logic                clk,
  input  logic                rst,
  input  rss_pkg::cell_ctrl_t ctrl,
  input  rss_pkg::entry_t     left_ent,
  input  logic                left_take,
  input  rss_pkg::entry_t     right_ent,
  output rss_pkg::entry_t     ent,
  output logic                take
);

  logic                       valid;
  logic [rss_pkg::KEY_W-1:0]  key;
  logic [rss_pkg::NODE_W-1:0] node;

  // new record belongs here or further left: strictly smaller key, or empty slot
  assign take = !valid || (ctrl.key < key);

  assign ent.valid = valid;
  assign ent.key   = key;
  assign ent.node  = node;

  // valid flag: insert fills or copies the left flag, drain pulls from the right
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && take) begin
      valid <= left_take ? left_ent.valid : 1'b1;
    end else if (ctrl.shift) begin
      valid <= right_ent.valid;
    end
  end

  // payload: ripple right on insert, left on drain
  always_ff @(posedge clk) begin
    if (ctrl.ins && take) begin
      if (left_take) begin
        key  <= left_ent.key;
        node <= left_ent.node;
      end else begin
        key  <= ctrl.key;
        node <= ctrl.node;
      end
    end else if (ctrl.shift) begin
      key  <= right_ent.key;
      node <= right_ent.node;
    end
  end

  // occupied cells form an unbroken run from the head
  `ASSERT_IMPLY(a_contig, valid, left_ent.valid, "gap in occupied cells")
  // neighbors stay in ascending key order
  `ASSERT_IMPLY(a_sorted, valid && left_ent.valid, left_ent.key <= key, "cells out of order")

endmodule

[dv/record_sort_by_score_top_tb.sv]
// testbench for the record sorter: directed and random batches of records, stable ascending order check
`timescale 1ns / 100ps

module record_sort_by_score_top_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 220;

  // record emitted by the sorter, with its end-of-run flag
  typedef struct packed {
    logic [rss_pkg::NODE_W-1:0] node;
    logic [rss_pkg::KEY_W-1:0]  key;
    logic                       is_end;
  } ordered_rec_t;

  // keeps the batch being loaded and the records due in sorted order
  class score_order_board;
    logic [rss_pkg::NODE_W-1:0] held_nodes[$];
    logic [rss_pkg::KEY_W-1:0]  held_keys[$];
    ordered_rec_t               sorted_due[$];
    int                         errors;

    function new();
      errors = 0;
    endfunction

    // store an accepted record; on the last one, sort the batch stably by score
    function void note_record(logic [rss_pkg::NODE_W-1:0] node,
                              logic [rss_pkg::KEY_W-1:0] key, logic is_last);
      logic [rss_pkg::NODE_W-1:0] nodes[rss_pkg::MAX_ENTRIES];
      logic [rss_pkg::KEY_W-1:0]  keys[rss_pkg::MAX_ENTRIES];
      logic [rss_pkg::NODE_W-1:0] v;
      logic [rss_pkg::KEY_W-1:0]  k;
      ordered_rec_t               rec;
      int                         n;
      int                         i;
      int                         j;
      // records past the capacity are dropped
      if (held_keys.size() < rss_pkg::MAX_ENTRIES) begin
        held_nodes.push_back(node);
        held_keys.push_back(key);
      end
      if (!is_last) return;
      n = held_keys.size();
      for (i = 0; i < n; i++) begin
        nodes[i] = held_nodes[i];
        keys[i]  = held_keys[i];
      end
      // insertion sort, strict compare keeps equal scores in arrival order
      for (i = 1; i < n; i++) begin
        k = keys[i];
        v = nodes[i];
        j = i;
        while (j > 0 && keys[j-1] > k) begin
          keys[j]  = keys[j-1];
          nodes[j] = nodes[j-1];
          j--;
        end
        keys[j]  = k;
        nodes[j] = v;
      end
      for (i = 0; i < n; i++) begin
        rec.node   = nodes[i];
        rec.key    = keys[i];
        rec.is_end = (i == n - 1);
        sorted_due.push_back(rec);
      end
      held_nodes.delete();
      held_keys.delete();
    endfunction

    // compare one emitted record with the oldest one due
    function void check_emitted(logic [rss_pkg::NODE_W-1:0] node,
                                logic [rss_pkg::KEY_W-1:0] key, logic is_end);
      ordered_rec_t want;
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual node %h score %h end %b",
                 $time, node, key, is_end);
        errors++;
        return;
      end
      want = sorted_due.pop_front();
      if (node !== want.node) begin
        $display("%0t: sorted_node mismatch: expected %h, actual %h",
                 $time, want.node, node);
        errors++;
      end
      if (key !== want.key) begin
        $display("%0t: sorted_score mismatch: expected %h, actual %h",
                 $time, want.key, key);
        errors++;
      end
      if (is_end !== want.is_end) begin
        $display("%0t: run_end mismatch: expected %b, actual %b",
                 $time, want.is_end, is_end);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [rss_pkg::NODE_W-1:0] node_id;
  logic [rss_pkg::KEY_W-1:0]  score;
  logic                       last_item;
  logic                       out_valid;
  logic                       out_stall;
  logic [rss_pkg::NODE_W-1:0] sorted_node;
  logic [rss_pkg::KEY_W-1:0]  sorted_score;
  logic                       run_end;

  score_order_board board;
  int               cycles;
  int               items_sent;
  int               stall_left;

  record_sort_by_score_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .node_id      (node_id),
    .score        (score),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_node  (sorted_node),
    .sorted_score (sorted_score),
    .run_end      (run_end)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("record_sort_by_score_top_tb NOT OK");
      $finish;
    end
  end

  // output side stall: bursts of stall and stretches of free flow
  always @(negedge clk) begin : stall_gen
    int r;
    if (rst) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        out_stall  = 1'b0;
        stall_left = $urandom_range(10, 40);
      end else if (r < 75) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 85) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(8, 20);
      end else begin
        out_stall  = 1'b0;
        stall_left = $urandom_range(1, 5);
      end
    end else begin
      stall_left--;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_emitted(sorted_node, sorted_score, run_end);
  end

  // idle cycles before a beat: mostly none or short, a few long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // drive one record beat; entered and left at a falling edge
  task automatic send_record(logic [rss_pkg::NODE_W-1:0] node,
                             logic [rss_pkg::KEY_W-1:0] key, logic is_last, bit quiet);
    int gap;
    gap = pick_gap(quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    node_id   = node;
    score     = key;
    last_item = is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_record(node, key, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  // random score drawn from a full, narrow or extreme-heavy range
  function automatic logic [rss_pkg::KEY_W-1:0] pick_score(int mode);
    case (mode)
      1: return rss_pkg::KEY_W'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 16'h0001;
          2: return 16'hFFFE;
          3: return 16'hFFFF;
          default: return rss_pkg::KEY_W'($urandom_range(0, 65535));
        endcase
      end
      default: return rss_pkg::KEY_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one batch of n random records, the last beat flagged
  task automatic send_batch(int n, int mode, bit quiet);
    int i;
    for (i = 0; i < n; i++)
      send_record(rss_pkg::NODE_W'($urandom_range(0, 65535)), pick_score(mode),
                  i == n - 1, quiet);
  endtask

  initial begin : stim
    int batch;
    int n;
    int r;
    board      = new();
    items_sent = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    node_id    = '0;
    score      = '0;
    last_item  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-record runs at the field extremes
    send_record(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_record(16'h0000, 16'h0000, 1'b1, 1'b1);
    // descending scores with a tie, then both score extremes
    send_record(16'd1, 16'd500, 1'b0, 1'b0);
    send_record(16'd2, 16'd400, 1'b0, 1'b0);
    send_record(16'd3, 16'd400, 1'b0, 1'b0);
    send_record(16'd4, 16'd100, 1'b0, 1'b0);
    send_record(16'd5, 16'hFFFF, 1'b0, 1'b0);
    send_record(16'd6, 16'h0000, 1'b1, 1'b0);
    // all scores equal: arrival order must hold
    send_record(16'hAAAA, 16'd7, 1'b0, 1'b1);
    send_record(16'h5555, 16'd7, 1'b0, 1'b1);
    send_record(16'h0F0F, 16'd7, 1'b0, 1'b1);
    send_record(16'hF0F0, 16'd7, 1'b1, 1'b1);
    // already in order
    send_record(16'h1234, 16'd0, 1'b0, 1'b0);
    send_record(16'h4321, 16'd1, 1'b0, 1'b0);
    send_record(16'h8000, 16'd2, 1'b1, 1'b0);

    // random batches; one exactly full, one overflowing the store
    batch = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (batch == 2)
        n = rss_pkg::MAX_ENTRIES;
      else if (batch == 5)
        n = rss_pkg::MAX_ENTRIES + 2;
      else if (r < 10)
        n = $urandom_range(11, 30);
      else
        n = $urandom_range(1, 8);
      send_batch(n, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
      batch++;
    end
    in_valid  = 1'b0;
    last_item = 1'b0;

    // drain what is still due, then a short settle
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0)
      $display("record_sort_by_score_top_tb OK");
    else
      $display("record_sort_by_score_top_tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rss_pkg.sv
rtl/rss_cell.sv
rtl/record_sort_by_score_top.sv
dv/record_sort_by_score_top_tb.sv
